// ===== rtl/ebalu_pkg.sv =====
// ----------------------------------------------------------------------------
// ebalu_pkg: shared types and constants of the 8-bit ALU with flags
// Holds the operation codes, the input and output word layouts, the flag bit
// positions and the decimal-adjust constants.
// ----------------------------------------------------------------------------
package ebalu_pkg;

  // Operation codes of the action field.
  typedef enum logic [4:0] {
    OP_ADD      = 5'd0,
    OP_ADC      = 5'd1,
    OP_SUB      = 5'd2,
    OP_SBC      = 5'd3,
    OP_AND      = 5'd4,
    OP_XOR      = 5'd5,
    OP_OR       = 5'd6,
    OP_CP       = 5'd7,
    OP_INC      = 5'd8,
    OP_DEC      = 5'd9,
    OP_RLCA     = 5'd10,
    OP_RRCA     = 5'd11,
    OP_RLA      = 5'd12,
    OP_RRA      = 5'd13,
    OP_RL       = 5'd14,
    OP_RR       = 5'd15,
    OP_SLA      = 5'd16,
    OP_SRL      = 5'd17,
    OP_SWAP     = 5'd18,
    OP_BIT      = 5'd19,
    OP_RES      = 5'd20,
    OP_SET      = 5'd21,
    OP_DAA      = 5'd22,
    OP_CPL      = 5'd23,
    OP_SCF      = 5'd24,
    OP_CCF      = 5'd25,
    OP_ADD16    = 5'd26,
    OP_ADD_SP_E = 5'd27,
    OP_INC16    = 5'd28,
    OP_DEC16    = 5'd29
  } op_e;

  // Flag bit positions inside the 4-bit flag word.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal-adjust constants.
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

  // Input word of one operation.
  typedef struct packed {
    logic [4:0]  action;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } alu_in_t;

  // Result word of one operation.
  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } alu_out_t;

endpackage

// ===== rtl/ebalu_exec.sv =====
// ----------------------------------------------------------------------------
// ebalu_exec: combinational execute stage
// Computes the result and the new Z/N/H/C flags of one operation from a
// registered input word.
// ----------------------------------------------------------------------------
module ebalu_exec (
  input  ebalu_pkg::alu_in_t  in_word_i,
  output ebalu_pkg::alu_out_t out_word_o
);
  import ebalu_pkg::*;

  op_e         op;
  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] wa;
  logic [15:0] wb;
  logic [3:0]  fi;
  logic        c;
  logic        cin_add;
  logic        cin_sub;
  logic [8:0]  add9;
  logic [4:0]  addh5;
  logic [8:0]  sub9;
  logic [4:0]  subh5;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  bit_mask;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_corr;
  logic [7:0]  daa_res;
  logic [16:0] add17;
  logic [12:0] add13;
  logic [15:0] spe16;
  logic [4:0]  speh5;
  logic [8:0]  spec9;
  logic [7:0]  r8;
  logic [15:0] res;
  logic [3:0]  fl;

  // Operand unpacking.
  assign op = op_e'(in_word_i.action);
  assign a  = in_word_i.operand_a[7:0];
  assign b  = in_word_i.operand_b[7:0];
  assign wa = in_word_i.operand_a;
  assign wb = in_word_i.operand_b;
  assign fi = in_word_i.flags_in;
  assign c  = fi[FLAG_C];

  // Byte adder and subtractor with half-carry taps.
  assign cin_add = (op == OP_ADC) ? c : 1'b0;
  assign cin_sub = (op == OP_SBC) ? c : 1'b0;
  assign add9  = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
  assign addh5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
  assign sub9  = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
  assign subh5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};
  assign inc8  = a + 8'd1;
  assign dec8  = a - 8'd1;

  // Single-bit mask for the bit operations.
  assign bit_mask = 8'd1 << in_word_i.bit_index;

  // Decimal adjust after an add or a subtract.
  assign daa_lo   = fi[FLAG_H] | (~fi[FLAG_N] & (a[3:0] > DAA_LO_LIMIT));
  assign daa_hi   = c | (~fi[FLAG_N] & (a > DAA_HI_LIMIT));
  assign daa_corr = (daa_lo ? DAA_LO_ADJ : 8'd0) | (daa_hi ? DAA_HI_ADJ : 8'd0);
  assign daa_res  = fi[FLAG_N] ? (a - daa_corr) : (a + daa_corr);

  // Wide adders: register-pair add and stack pointer plus signed offset.
  assign add17 = {1'b0, wa} + {1'b0, wb};
  assign add13 = {1'b0, wa[11:0]} + {1'b0, wb[11:0]};
  assign spe16 = wa + {{8{b[7]}}, b};
  assign speh5 = {1'b0, wa[3:0]} + {1'b0, b[3:0]};
  assign spec9 = {1'b0, wa[7:0]} + {1'b0, b};

  // Result and flag selection.
  always_comb begin
    r8  = a;
    res = wa;
    fl  = fi;
    case (op)
      OP_ADD, OP_ADC: begin
        r8 = add9[7:0];
        fl = {(add9[7:0] == 8'd0), 1'b0, addh5[4], add9[8]};
      end
      OP_SUB, OP_SBC: begin
        r8 = sub9[7:0];
        fl = {(sub9[7:0] == 8'd0), 1'b1, subh5[4], sub9[8]};
      end
      OP_CP: begin
        r8 = a;
        fl = {(sub9[7:0] == 8'd0), 1'b1, subh5[4], sub9[8]};
      end
      OP_AND: begin
        r8 = a & b;
        fl = {(r8 == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r8 = a ^ b;
        fl = {(r8 == 8'd0), 3'b000};
      end
      OP_OR: begin
        r8 = a | b;
        fl = {(r8 == 8'd0), 3'b000};
      end
      OP_INC: begin
        r8 = inc8;
        fl = {(inc8 == 8'd0), 1'b0, (a[3:0] == 4'hF), c};
      end
      OP_DEC: begin
        r8 = dec8;
        fl = {(dec8 == 8'd0), 1'b1, (a[3:0] == 4'h0), c};
      end
      OP_RLCA: begin
        r8 = {a[6:0], a[7]};
        fl = {3'b000, a[7]};
      end
      OP_RRCA: begin
        r8 = {a[0], a[7:1]};
        fl = {3'b000, a[0]};
      end
      OP_RLA: begin
        r8 = {a[6:0], c};
        fl = {3'b000, a[7]};
      end
      OP_RRA: begin
        r8 = {c, a[7:1]};
        fl = {3'b000, a[0]};
      end
      OP_RL: begin
        r8 = {a[6:0], c};
        fl = {(r8 == 8'd0), 2'b00, a[7]};
      end
      OP_RR: begin
        r8 = {c, a[7:1]};
        fl = {(r8 == 8'd0), 2'b00, a[0]};
      end
      OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        fl = {(r8 == 8'd0), 2'b00, a[7]};
      end
      OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        fl = {(r8 == 8'd0), 2'b00, a[0]};
      end
      OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        fl = {(r8 == 8'd0), 3'b000};
      end
      OP_BIT: begin
        r8 = a;
        fl = {~a[in_word_i.bit_index], 1'b0, 1'b1, c};
      end
      OP_RES: begin
        r8 = a & ~bit_mask;
      end
      OP_SET: begin
        r8 = a | bit_mask;
      end
      OP_DAA: begin
        r8 = daa_res;
        fl = {(daa_res == 8'd0), fi[FLAG_N], 1'b0, daa_hi};
      end
      OP_CPL: begin
        r8 = ~a;
        fl = {fi[FLAG_Z], 1'b1, 1'b1, c};
      end
      OP_SCF: begin
        r8 = a;
        fl = {fi[FLAG_Z], 2'b00, 1'b1};
      end
      OP_CCF: begin
        r8 = a;
        fl = {fi[FLAG_Z], 2'b00, ~c};
      end
      default: begin
        r8 = a;
      end
    endcase

    // Wide ops return 16 bits; byte ops a zero-extended byte; spare codes wa.
    case (op)
      OP_ADD16: begin
        res = add17[15:0];
        fl  = {fi[FLAG_Z], 1'b0, add13[12], add17[16]};
      end
      OP_ADD_SP_E: begin
        res = spe16;
        fl  = {2'b00, speh5[4], spec9[8]};
      end
      OP_INC16: res = wa + 16'd1;
      OP_DEC16: res = wa - 16'd1;
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_XOR, OP_OR, OP_CP,
      OP_INC, OP_DEC, OP_RLCA, OP_RRCA, OP_RLA, OP_RRA, OP_RL, OP_RR,
      OP_SLA, OP_SRL, OP_SWAP, OP_BIT, OP_RES, OP_SET, OP_DAA, OP_CPL,
      OP_SCF, OP_CCF: res = {8'd0, r8};
      default: res = wa;
    endcase
  end

  assign out_word_o.result    = res;
  assign out_word_o.flags_out = fl;

endmodule

// ===== rtl/eight_bit_alu_with_flags_core.sv =====
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_core: 8-bit ALU with Z/N/H/C flags
// Input register, combinational execute stage and result register.
// ----------------------------------------------------------------------------
// Usage:
//   A word (operation, two operands, bit number, incoming flags) is taken on
//   in_word_i at every rising edge where start is high and busy is low. The
//   block never raises busy, so a new word may be given in every cycle.
//   Each word is held in the input register while the execute
//   stage computes the result and new flags; the result register captures
//   them at the next edge.
//   The result word appears on out_word_o with done_o high for exactly one
//   cycle, starting at the first edge after the one that took the word; the
//   receiver takes it at the edge after that. Throughput is one word per
//   cycle; a single execute stage lies between the two registers.
//   The receiver has no way to hold results off and must take each one in
//   the cycle that done_o marks.
//   Reset clears the input valid and done_o; words in flight are dropped.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ebalu_pkg::alu_in_t  in_word_i,
  output logic                done_o,
  output ebalu_pkg::alu_out_t out_word_o
);
  import ebalu_pkg::*;

  logic     accept;
  logic     valid_q;
  alu_in_t  in_q;
  alu_out_t exec_out;
  alu_out_t out_q;
  logic     done_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
  end

  // Execute stage.
  ebalu_exec u_exec (
    .in_word_i  (in_q),
    .out_word_o (exec_out)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      out_q <= exec_out;
    end
  end

  assign done_o     = done_q;
  assign out_word_o = out_q;

  // Every accepted word yields a result after the input and result registers.
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted word produced no result");

  // A result is only signaled for a word that was in the input register.
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_q))
    else $error("result strobe without a word in execution");

  // Wide increment/decrement and bit reset/set leave the flags untouched.
  a_flags_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (op_e'(in_q.action) == OP_INC16 || op_e'(in_q.action) == OP_DEC16 ||
                op_e'(in_q.action) == OP_RES || op_e'(in_q.action) == OP_SET)
    |=> out_word_o.flags_out == $past(in_q.flags_in))
    else $error("flags changed by a flag-preserving operation");

  // Compare returns the accumulator unchanged.
  a_cp_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && op_e'(in_q.action) == OP_CP
    |=> out_word_o.result == {8'd0, $past(in_q.operand_a[7:0])})
    else $error("compare altered the accumulator");

endmodule

// ===== dv/eight_bit_alu_with_flags_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_core_test: self-checking bench for the flag ALU
// Drives operation words through the start/busy handshake and predicts the
// result and new Z/N/H/C flags of each one. Every result word is compared
// against the oldest prediction. Stimulus runs from a directed sweep of all
// action codes to random words, decimal-adjust chains and a final stretch at
// full rate. The sender pauses in random bursts along the way.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_core_test;
  import ebalu_pkg::*;

  // Action codes outside the operation set; the block passes the word through.
  localparam logic [4:0] OP_SPARE_LO = 5'd30;
  localparam logic [4:0] OP_SPARE_HI = 5'd31;

  localparam int unsigned TIMEOUT_NS   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned TAIL_CYCLES  = 6;

  // A prediction together with the word that caused it, for reporting.
  typedef struct packed {
    alu_in_t  op_word;
    alu_out_t want;
  } alu_check_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     start     = 1'b0;
  alu_in_t  in_word_i = '0;
  logic     busy;
  logic     done_o;
  alu_out_t out_word_o;

  alu_check_t  pending_results[$];
  alu_check_t  head_entry;
  int unsigned mismatch_count  = 0;
  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  logic [31:0] codes_seen      = '0;

  eight_bit_alu_with_flags_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_word_i  (in_word_i),
    .done_o     (done_o),
    .out_word_o (out_word_o)
  );

  // 100 MHz clock.
  always #5 clk_i = ~clk_i;

  // Predict the result word of one operation word.
  // Flag words are built as {Z, N, H, C}, matching the package bit positions.
  function automatic alu_out_t predict_alu(input alu_in_t w);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  r8;
    logic [7:0]  adj;
    logic [15:0] r;
    logic [3:0]  f;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic        cin;
    logic        cy;
    logic        cout;
    alu_out_t    o;
    a    = w.operand_a[7:0];
    b    = w.operand_b[7:0];
    cin  = w.flags_in[FLAG_C];
    f    = w.flags_in;
    r    = w.operand_a;
    r8   = a;
    case (w.action)
      OP_ADD, OP_ADC: begin
        cy   = (w.action == OP_ADC) ? cin : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cy};
        nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
        r8   = sum9[7:0];
        f    = {r8 == 8'h00, 1'b0, nib5[4], sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cy   = (w.action == OP_SBC) ? cin : 1'b0;
        sum9 = {1'b0, a} - {1'b0, b} - {8'd0, cy};
        nib5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};
        r8   = (w.action == OP_CP) ? a : sum9[7:0];
        f    = {sum9[7:0] == 8'h00, 1'b1, nib5[4], sum9[8]};
      end
      OP_AND: begin
        r8 = a & b;
        f  = {r8 == 8'h00, 3'b010};
      end
      OP_XOR: begin
        r8 = a ^ b;
        f  = {r8 == 8'h00, 3'b000};
      end
      OP_OR: begin
        r8 = a | b;
        f  = {r8 == 8'h00, 3'b000};
      end
      OP_INC: begin
        r8 = a + 8'd1;
        f  = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
      end
      OP_DEC: begin
        r8 = a - 8'd1;
        f  = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
      end
      // Accumulator rotates always clear Z.
      OP_RLCA: begin
        r8 = {a[6:0], a[7]};
        f  = {3'b000, a[7]};
      end
      OP_RRCA: begin
        r8 = {a[0], a[7:1]};
        f  = {3'b000, a[0]};
      end
      OP_RLA: begin
        r8 = {a[6:0], cin};
        f  = {3'b000, a[7]};
      end
      OP_RRA: begin
        r8 = {cin, a[7:1]};
        f  = {3'b000, a[0]};
      end
      // Prefixed rotates and shifts set Z from the result.
      OP_RL: begin
        r8 = {a[6:0], cin};
        f  = {r8 == 8'h00, 2'b00, a[7]};
      end
      OP_RR: begin
        r8 = {cin, a[7:1]};
        f  = {r8 == 8'h00, 2'b00, a[0]};
      end
      OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        f  = {r8 == 8'h00, 2'b00, a[7]};
      end
      OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        f  = {r8 == 8'h00, 2'b00, a[0]};
      end
      OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        f  = {r8 == 8'h00, 3'b000};
      end
      OP_BIT: begin
        f = {~a[w.bit_index], 2'b01, cin};
      end
      OP_RES: begin
        r8[w.bit_index] = 1'b0;
      end
      OP_SET: begin
        r8[w.bit_index] = 1'b1;
      end
      // Decimal adjust after a BCD add or subtract.
      OP_DAA: begin
        adj  = 8'h00;
        cout = cin;
        if (w.flags_in[FLAG_H] || (!w.flags_in[FLAG_N] && a[3:0] > DAA_LO_LIMIT)) begin
          adj = adj | DAA_LO_ADJ;
        end
        if (cin || (!w.flags_in[FLAG_N] && a > DAA_HI_LIMIT)) begin
          adj  = adj | DAA_HI_ADJ;
          cout = 1'b1;
        end
        r8 = w.flags_in[FLAG_N] ? a - adj : a + adj;
        f  = {r8 == 8'h00, w.flags_in[FLAG_N], 1'b0, cout};
      end
      OP_CPL: begin
        r8 = ~a;
        f  = {w.flags_in[FLAG_Z], 2'b11, cin};
      end
      OP_SCF: begin
        f = {w.flags_in[FLAG_Z], 3'b001};
      end
      OP_CCF: begin
        f = {w.flags_in[FLAG_Z], 2'b00, ~cin};
      end
      // Wide ops give 16-bit results; ADD16 uses all 16 bits of both operands.
      OP_ADD16: begin
        sum17 = {1'b0, w.operand_a} + {1'b0, w.operand_b};
        sum13 = {1'b0, w.operand_a[11:0]} + {1'b0, w.operand_b[11:0]};
        r     = sum17[15:0];
        f     = {w.flags_in[FLAG_Z], 1'b0, sum13[12], sum17[16]};
      end
      OP_ADD_SP_E: begin
        r    = w.operand_a + {{8{b[7]}}, b};
        nib5 = {1'b0, w.operand_a[3:0]} + {1'b0, b[3:0]};
        sum9 = {1'b0, w.operand_a[7:0]} + {1'b0, b};
        f    = {2'b00, nib5[4], sum9[8]};
      end
      OP_INC16: begin
        r = w.operand_a + 16'd1;
      end
      OP_DEC16: begin
        r = w.operand_a - 16'd1;
      end
      default: begin
        r = w.operand_a;
        f = w.flags_in;
      end
    endcase
    // Byte operations return the low byte with a zero high byte.
    if (w.action <= OP_CCF) begin
      r = {8'h00, r8};
    end
    o.result    = r;
    o.flags_out = f;
    return o;
  endfunction

  function automatic alu_in_t pack_word(input logic [4:0] act, input logic [15:0] opa,
                                        input logic [15:0] opb, input logic [2:0] bidx,
                                        input logic [3:0] flg);
    alu_in_t w;
    w.action    = act;
    w.operand_a = opa;
    w.operand_b = opb;
    w.bit_index = bidx;
    w.flags_in  = flg;
    return w;
  endfunction

  // Operands lean on nibble and byte boundaries a third of the time.
  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 11))
      0: v[7:0] = 8'h00;
      1: v[7:0] = 8'hFF;
      2: v[7:0] = {4'($urandom), 4'hF};
      3: v[11:0] = 12'hFFF;
      default: ;
    endcase
    return v;
  endfunction

  function automatic alu_in_t random_word(input logic [4:0] act);
    return pack_word(act, pick_operand(), pick_operand(), 3'($urandom), 4'($urandom));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Present one word and hold it until the block takes it.
  task automatic send_word(input alu_in_t w);
    alu_check_t entry;
    start     <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    entry.op_word = w;
    entry.want    = predict_alu(w);
    pending_results.push_back(entry);
    codes_seen[w.action] = 1'b1;
    words_sent++;
  endtask

  // Drop start for some cycles; the word lines carry junk meanwhile.
  task automatic pause(input int unsigned cycles);
    repeat (cycles) begin
      start     <= 1'b0;
      in_word_i <= random_word(5'($urandom));
      @(posedge clk_i);
    end
  endtask

  task automatic random_gap(input bit allow);
    if (allow && $urandom_range(0, 4) == 0) begin
      pause($urandom_range(1, 13));
    end
  endtask

  // Every action code once, on carry, zero and boundary corners.
  task automatic test_directed_corners();
    send_word(pack_word(OP_ADD,      16'h00FF, 16'h0001, 3'd0, 4'h0));
    send_word(pack_word(OP_ADC,      16'hFF0F, 16'hFF00, 3'd0, 4'h1));
    send_word(pack_word(OP_SUB,      16'h0000, 16'h0001, 3'd0, 4'h0));
    send_word(pack_word(OP_SBC,      16'h0010, 16'h000F, 3'd0, 4'h1));
    send_word(pack_word(OP_AND,      16'hFFFF, 16'h0000, 3'd0, 4'hF));
    send_word(pack_word(OP_XOR,      16'h00FF, 16'hFFFF, 3'd0, 4'h0));
    send_word(pack_word(OP_OR,       16'h0000, 16'h0000, 3'd0, 4'hF));
    send_word(pack_word(OP_CP,       16'h0042, 16'h0042, 3'd0, 4'h0));
    send_word(pack_word(OP_INC,      16'h00FF, 16'h0000, 3'd0, 4'h1));
    send_word(pack_word(OP_DEC,      16'h0010, 16'h0000, 3'd0, 4'h0));
    send_word(pack_word(OP_RLCA,     16'h0080, 16'h0000, 3'd0, 4'hF));
    send_word(pack_word(OP_RRCA,     16'h0001, 16'h0000, 3'd0, 4'h8));
    send_word(pack_word(OP_RLA,      16'h0080, 16'h0000, 3'd0, 4'h1));
    send_word(pack_word(OP_RRA,      16'h0001, 16'h0000, 3'd0, 4'h0));
    send_word(pack_word(OP_RL,       16'h0080, 16'h0000, 3'd0, 4'h0));
    send_word(pack_word(OP_RR,       16'h0000, 16'h0000, 3'd0, 4'h1));
    send_word(pack_word(OP_SLA,      16'hFFFF, 16'h0000, 3'd0, 4'h0));
    send_word(pack_word(OP_SRL,      16'h0001, 16'h0000, 3'd0, 4'h0));
    send_word(pack_word(OP_SWAP,     16'h00F0, 16'h0000, 3'd0, 4'h0));
    send_word(pack_word(OP_BIT,      16'h0080, 16'h0000, 3'd7, 4'h1));
    send_word(pack_word(OP_RES,      16'hFFFF, 16'h0000, 3'd7, 4'hF));
    send_word(pack_word(OP_SET,      16'h0000, 16'h0000, 3'd0, 4'h0));
    send_word(pack_word(OP_DAA,      16'h009A, 16'h0000, 3'd0, 4'h0));
    send_word(pack_word(OP_CPL,      16'h0055, 16'h0000, 3'd0, 4'h9));
    send_word(pack_word(OP_SCF,      16'h0012, 16'h0000, 3'd0, 4'hF));
    send_word(pack_word(OP_CCF,      16'h0012, 16'h0000, 3'd0, 4'h1));
    send_word(pack_word(OP_ADD16,    16'hFFFF, 16'h0001, 3'd0, 4'h8));
    send_word(pack_word(OP_ADD_SP_E, 16'h0000, 16'h00FF, 3'd0, 4'hF));
    send_word(pack_word(OP_INC16,    16'hFFFF, 16'h0000, 3'd0, 4'hF));
    send_word(pack_word(OP_DEC16,    16'h0000, 16'h0000, 3'd0, 4'h0));
    send_word(pack_word(OP_SPARE_LO, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF));
    send_word(pack_word(OP_SPARE_HI, 16'h1234, 16'h0000, 3'd0, 4'h6));
  endtask

  // Random words over all 32 action codes, with the sender pausing at random.
  task automatic test_random_words(input int unsigned count);
    bit idle_on;
    idle_on = 1'b1;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        idle_on = ($urandom_range(0, 2) != 0);
      end
      send_word(random_word(5'($urandom_range(0, 31))));
      random_gap(idle_on);
    end
  endtask

  // BCD add or subtract followed by a decimal adjust fed with its own result;
  // one chain in eight gets random flags instead.
  task automatic test_decimal_chains(input int unsigned count);
    alu_in_t  first;
    alu_out_t mid;
    logic [4:0] act;
    logic [3:0] flg;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: act = OP_ADD;
        1: act = OP_ADC;
        2: act = OP_SUB;
        default: act = OP_SBC;
      endcase
      first = pack_word(act,
                        {8'($urandom), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))},
                        {8'($urandom), 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))},
                        3'($urandom), 4'($urandom));
      mid = predict_alu(first);
      send_word(first);
      random_gap(1'b1);
      flg = ($urandom_range(0, 7) == 0) ? 4'($urandom) : mid.flags_out;
      send_word(pack_word(OP_DAA, {8'($urandom), mid.result[7:0]}, 16'($urandom),
                          3'($urandom), flg));
      random_gap(1'b1);
    end
  endtask

  // Full-rate stretch with no pauses at all.
  task automatic test_back_to_back(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_word(random_word(5'($urandom_range(0, 31))));
    end
  endtask

  // Compare each result word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with no operation outstanding",
                                  out_word_o));
      end else begin
        head_entry = pending_results.pop_front();
        results_checked++;
        if (out_word_o.result !== head_entry.want.result) begin
          report_mismatch($sformatf("action %0d a=%h b=%h: result %h, predicted %h",
                                    head_entry.op_word.action, head_entry.op_word.operand_a,
                                    head_entry.op_word.operand_b, out_word_o.result,
                                    head_entry.want.result));
        end
        if (out_word_o.flags_out !== head_entry.want.flags_out) begin
          report_mismatch($sformatf("action %0d a=%h b=%h f=%h: flags %b, predicted %b",
                                    head_entry.op_word.action, head_entry.op_word.operand_a,
                                    head_entry.op_word.operand_b, head_entry.op_word.flags_in,
                                    out_word_o.flags_out, head_entry.want.flags_out));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int unsigned drain;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_words(1200);
    test_decimal_chains(100);
    test_back_to_back(200);

    start <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_CYCLES) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
                                pending_results.size()));
    end

    $display("Sent %0d words covering %0d of 32 action codes; %0d results checked.",
             words_sent, $countones(codes_seen), results_checked);
    $display("Mismatches found: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("Watchdog expired with %0d results outstanding.", pending_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ebalu_pkg.sv
rtl/ebalu_exec.sv
rtl/eight_bit_alu_with_flags_core.sv
dv/eight_bit_alu_with_flags_core_test.sv
